@@ rtl/physical_address_decoder_defines.svh @@
// Assertion macros for the physical address decoder.
// Used by the top level; no other dependencies.
`ifndef PHYSICAL_ADDRESS_DECODER_DEFINES_SVH
`define PHYSICAL_ADDRESS_DECODER_DEFINES_SVH

`ifndef SYNTH
`define PAD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pad assertion failed");
`define PAD_ASSERT_VALID(label, vld, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (vld) |-> (prop)) \
        else $error("pad result check failed");
`else
`define PAD_ASSERT(label, prop)
`define PAD_ASSERT_VALID(label, vld, prop)
`endif

`endif

@@ rtl/pad_pkg.sv @@
// Shared types and constants of the physical address decoder.
// No dependencies.
`timescale 1ns / 1ps

package pad_pkg;

    typedef enum logic [3:0] {
        TGT_NONE     = 4'd0,
        TGT_ROM      = 4'd1,
        TGT_VRAM     = 4'd2,
        TGT_IOC      = 4'd3,
        TGT_MOUSE    = 4'd4,
        TGT_SUPERIO  = 4'd5,
        TGT_IDEW     = 4'd6,
        TGT_IDEB     = 4'd7,
        TGT_FDC      = 4'd8,
        TGT_PODULE   = 4'd9,
        TGT_BANK0    = 4'd10,
        TGT_BANK1    = 4'd11,
        TGT_SIMM1    = 4'd12,
        TGT_VIDEO    = 4'd13
    } target_t;

    typedef enum logic [2:0] {
        CFG_SECOND_MODEL = 3'd0,
        CFG_OLD_IOC      = 3'd1,
        CFG_RAM_MASK     = 3'd2,
        CFG_VRAM_MASK    = 3'd3,
        CFG_SIMM1        = 3'd4,
        CFG_VIDEO_START  = 3'd5
    } cfg_idx_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;

    typedef struct packed {
        logic        second_model_mode;
        logic        old_io_controller;
        logic [25:0] ram_bank_mask;
        logic [22:0] vram_mask;
        logic        simm1_present;
        logic [9:0]  video_start_region;
    } cfg_t;

    typedef struct packed {
        logic        op;
        logic        byte_access;
        logic [31:0] bus_address;
        logic [31:0] write_data;
    } req_t;

    typedef struct packed {
        target_t     target;
        logic [26:0] local_offset;
        logic [2:0]  slot;
        logic        easi_space;
        logic [31:0] device_data;
        logic [31:0] unmapped_data;
        logic        dirty_valid;
        logic [13:0] dirty_page;
    } rsp_t;

    localparam logic [29:0] SPACE_1G     = 30'h3fff_ffff;
    localparam logic [29:0] SPACE_512M   = 30'h1fff_ffff;
    localparam logic [31:0] ROM_MASK     = 32'h007f_ffff;
    localparam logic [31:0] SIMM1_MASK   = 32'h07ff_ffff;
    localparam logic [31:0] SIO_LO       = 32'h0301_0000;
    localparam logic [31:0] FDC_LO       = 32'h0301_2000;
    localparam logic [31:0] FDC_HI       = 32'h0302_a000;
    localparam logic [31:0] MOUSE_ADDR   = 32'h0331_0000;
    localparam logic [31:0] IDE2_W_ADDR  = 32'h0080_07c0;
    localparam logic [31:0] VIDEO_BASE   = 32'h0040_0000;
    localparam logic [31:0] IGN_WIN_A    = 32'h033a_0000;
    localparam logic [31:0] IGN_WIN_B    = 32'h0024_0000;

    localparam logic [5:0] CHUNK_ROM  = 6'd0;
    localparam logic [5:0] CHUNK_VRAM = 6'd2;
    localparam logic [5:0] CHUNK_IO   = 6'd3;

endpackage

@@ rtl/pad_cfg.sv @@
// Configuration register file of the physical address decoder.
// Depends on pad_pkg.
`timescale 1ns / 1ps

module pad_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pad_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pad_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output pad_pkg::cfg_t                    cfg
);
    import pad_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SECOND_MODEL: cfg_next.second_model_mode  = cfg_wdata[0];
                CFG_OLD_IOC:      cfg_next.old_io_controller  = cfg_wdata[0];
                CFG_RAM_MASK:     cfg_next.ram_bank_mask      = cfg_wdata[25:0];
                CFG_VRAM_MASK:    cfg_next.vram_mask          = cfg_wdata[22:0];
                CFG_SIMM1:        cfg_next.simm1_present      = cfg_wdata[0];
                CFG_VIDEO_START:  cfg_next.video_start_region = cfg_wdata[9:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.second_model_mode  <= 1'b0;
            cfg_reg.old_io_controller  <= 1'b1;
            cfg_reg.ram_bank_mask      <= 26'h01f_ffff;
            cfg_reg.vram_mask          <= '0;
            cfg_reg.simm1_present      <= 1'b0;
            cfg_reg.video_start_region <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/pad_decode.sv @@
// Combinational decode of one bus transaction into target, offset and data.
// Depends on pad_pkg.
`timescale 1ns / 1ps

module pad_decode (
    input  pad_pkg::cfg_t cfg,
    input  pad_pkg::req_t req,
    output pad_pkg::rsp_t rsp
);
    import pad_pkg::*;

    logic        wr;
    logic        by;
    logic [29:0] a30;
    logic [31:0] a;
    logic [5:0]  chunk;
    logic [2:0]  bank;
    logic        sio;
    logic        fdc;
    logic [22:0] vram_off;
    logic [25:0] ram_off;
    target_t     tgt;
    logic [31:0] off;
    logic [2:0]  slot;
    logic        easi;
    logic [31:0] unm;
    logic        dv;
    logic [13:0] dp;
    logic [31:0] data;

    assign wr       = req.op;
    assign by       = req.byte_access;
    assign a30      = req.bus_address[29:0] & (cfg.second_model_mode ? SPACE_1G : SPACE_512M);
    assign a        = {2'b00, a30};
    assign chunk    = a30[29:24];
    assign bank     = a[18:16];
    assign sio      = (a >= SIO_LO) && (a < FDC_LO);
    assign fdc      = (a >= FDC_LO) && (a <= FDC_HI);
    assign vram_off = a[22:0] & cfg.vram_mask;
    assign ram_off  = a[25:0] & cfg.ram_bank_mask;

    always_comb
    begin
        tgt  = TGT_NONE;
        off  = '0;
        slot = '0;
        easi = 1'b0;
        unm  = by ? 32'h0000_00ff : 32'h0;
        dv   = 1'b0;
        dp   = '0;

        if (chunk == CHUNK_ROM)
        begin
            if (!wr)
            begin
                tgt = TGT_ROM;
                off = a & ROM_MASK;
            end
        end
        else if (chunk == CHUNK_VRAM)
        begin
            if (cfg.vram_mask == '0)
            begin
                unm = by ? 32'h0000_00ff : 32'hffff_ffff;
            end
            else
            begin
                tgt = TGT_VRAM;
                off = {9'd0, vram_off};
                dv  = wr;
                dp  = wr ? {3'd0, vram_off[22:12]} : 14'd0;
            end
        end
        else if (chunk == CHUNK_IO)
        begin
            if (a[23:22] == 2'b00)
            begin
                if (bank == 3'd0)
                begin
                    tgt = TGT_IOC;
                    off = a;
                end
                else if (bank == 3'd1 || bank == 3'd2)
                begin
                    if (!wr)
                    begin
                        if (a == MOUSE_ADDR && cfg.old_io_controller)
                        begin
                            tgt = TGT_MOUSE;
                            off = a;
                        end
                        else if (by && fdc)
                        begin
                            tgt = TGT_FDC;
                            off = a;
                        end
                        else if (by && (a[23:0] & 24'hfff400) == 24'h02b000)
                        begin
                            // network card window reads float high
                            unm = 32'hffff_ffff;
                        end
                        else if (sio)
                        begin
                            if (!by && (a & 32'hffc) == 32'h7c0)
                                tgt = TGT_IDEW;
                            else
                            begin
                                tgt = TGT_SUPERIO;
                                off = a;
                            end
                        end
                    end
                    else if (!by)
                    begin
                        if (sio)
                        begin
                            if ((a & 32'hffc) == 32'h7c0)
                                tgt = TGT_IDEW;
                            else
                            begin
                                tgt = TGT_SUPERIO;
                                off = a;
                            end
                        end
                    end
                    else
                    begin
                        if (a == MOUSE_ADDR || (a & 32'hfc0000) == IGN_WIN_B)
                        begin
                            tgt = TGT_NONE;
                        end
                        else if (fdc)
                        begin
                            tgt = TGT_FDC;
                            off = a;
                        end
                        else if (sio)
                        begin
                            tgt = TGT_SUPERIO;
                            off = a;
                        end
                    end
                end
                else if (bank == 3'd4 || bank == 3'd7)
                begin
                    tgt  = TGT_PODULE;
                    off  = a & 32'h3fff;
                    slot = {bank == 3'd7, a[15:14]};
                end
            end
            else if (wr && !by && (a & 32'hc00000) == VIDEO_BASE)
            begin
                tgt = TGT_VIDEO;
            end
            else if (cfg.second_model_mode)
            begin
                if (!by && (a & 32'hcffffc) == IDE2_W_ADDR)
                    tgt = TGT_IDEW;
                else if (by && (a & 32'hcff000) == (IDE2_W_ADDR & 32'hfff000))
                begin
                    tgt = TGT_IDEB;
                    off = {22'd0, a[11:2]};
                end
            end
        end
        else if (chunk[5:3] == 3'b001)
        begin
            tgt  = TGT_PODULE;
            off  = a & 32'h00ff_ffff;
            slot = chunk[2:0];
            easi = 1'b1;
        end
        else if (chunk[5:2] == 4'b0100)
        begin
            tgt = TGT_BANK0;
            off = {6'd0, ram_off};
            if (wr && cfg.vram_mask == '0 && a[31:22] == cfg.video_start_region)
            begin
                dv = 1'b1;
                dp = ram_off[25:12];
            end
        end
        else if (chunk[5:2] == 4'b0101)
        begin
            tgt = TGT_BANK1;
            off = {6'd0, ram_off};
        end
        else if (chunk[5:3] == 3'b011)
        begin
            if (cfg.simm1_present)
            begin
                tgt = TGT_SIMM1;
                off = a & SIMM1_MASK;
            end
        end

        if (tgt != TGT_NONE || wr)
            unm = '0;

        data = '0;
        if (wr && tgt != TGT_NONE)
        begin
            if (by)
                data = {24'd0, req.write_data[7:0]};
            else if (tgt == TGT_PODULE && !easi)
                data = {16'd0, req.write_data[31:16]};
            else
                data = req.write_data;
        end
    end

    assign rsp.target        = tgt;
    assign rsp.local_offset  = off[26:0];
    assign rsp.slot          = slot;
    assign rsp.easi_space    = easi;
    assign rsp.device_data   = data;
    assign rsp.unmapped_data = unm;
    assign rsp.dirty_valid   = dv;
    assign rsp.dirty_page    = dp;

endmodule

@@ rtl/physical_address_decoder.sv @@
// Physical address decoder: the configuration registers, the input register,
// the decode logic and the result register. Depends on pad_pkg, pad_cfg, pad_decode.
`timescale 1ns / 1ps
`include "physical_address_decoder_defines.svh"

// Decodes one bus transaction per clock unless the result channel stalls. A
// transaction is captured in the input register, decoded in one pass of
// combinational logic and delivered from the result register; with out_ready
// held high a new transaction is taken every cycle. Backpressure stalls both
// stages in place, and a stage frees up in the same cycle its contents move on.
// Configuration writes take effect on the next clock; the user must make them
// only while no transaction is in flight, as the block does not enforce it.
module physical_address_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  pad_pkg::req_t                  in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output pad_pkg::rsp_t                  out_data,
    input  logic                           cfg_we,
    input  logic [pad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pad_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import pad_pkg::*;

    cfg_t cfg;
    req_t s1_data_reg;
    logic s1_valid_reg;
    logic s1_valid_next;
    rsp_t dec_rsp;
    rsp_t out_data_reg;
    logic out_valid_reg;
    logic out_valid_next;
    logic in_fire;
    logic s1_adv;

    pad_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pad_decode u_decode (
        .cfg (cfg),
        .req (s1_data_reg),
        .rsp (dec_rsp)
    );

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_data_reg <= in_data;
        if (s1_adv)
            out_data_reg <= dec_rsp;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a stalled input-stage transaction is never dropped
    `PAD_ASSERT(a_s1_hold, (s1_valid_reg && !s1_adv) |=> s1_valid_reg)
    `PAD_ASSERT_VALID(a_dirty_tgt, out_valid && out_data.dirty_valid, out_data.target == TGT_VRAM || out_data.target == TGT_BANK0)
    `PAD_ASSERT_VALID(a_unm_zero, out_valid && out_data.target != TGT_NONE, out_data.unmapped_data == 32'h0)
    `PAD_ASSERT_VALID(a_slot_pod, out_valid && out_data.target != TGT_PODULE, out_data.slot == 3'd0 && !out_data.easi_space)

endmodule

@@ tb/pad_decode_checker.sv @@
// Checker for the physical address decoder: mirrors the register writes, predicts
// each decode on the input channel and compares it with the result channel.
// Depends on pad_pkg.
`timescale 1ns / 1ps

module pad_decode_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  pad_pkg::req_t                  in_data,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  pad_pkg::rsp_t                  out_data,
    input  logic                           cfg_we,
    input  logic [pad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pad_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             pending,
    output int                             errors
);
    import pad_pkg::*;

    cfg_t cfg_now;
    rsp_t expected_decodes[$];
    int   result_count;

    task automatic report_mismatch(input string what);
        $display("%0t pad_decode_checker: result %0d: %s", $time, result_count, what);
        errors++;
    endtask

    function automatic rsp_t decode_access(req_t rq, cfg_t c);
        rsp_t        r;
        logic [31:0] a;
        logic [31:0] wd;
        logic [31:0] masked;
        logic [7:0]  chunk;
        logic [2:0]  bank;
        logic        wr;
        logic        by;
        logic        sio;
        logic        fdc;
        wr = rq.op;
        by = rq.byte_access;
        wd = rq.write_data;
        a  = rq.bus_address & (c.second_model_mode ? 32'h3fff_ffff : 32'h1fff_ffff);
        chunk = a[31:24];
        r = '0;
        r.target = TGT_NONE;
        r.unmapped_data = by ? 32'h0000_00ff : 32'h0;

        if (chunk == 8'd0)
        begin
            if (!wr)
            begin
                r.target = TGT_ROM;
                r.local_offset = {4'd0, a[22:0]};
            end
        end
        else if (chunk == 8'd2)
        begin
            if (c.vram_mask == '0)
                r.unmapped_data = by ? 32'h0000_00ff : 32'hffff_ffff;
            else
            begin
                masked = a & {9'd0, c.vram_mask};
                r.target = TGT_VRAM;
                r.local_offset = masked[26:0];
                if (wr)
                begin
                    r.dirty_valid = 1'b1;
                    r.dirty_page = masked[25:12];
                end
            end
        end
        else if (chunk == 8'd3)
        begin
            if (a[23:22] == 2'b00)
            begin
                bank = a[18:16];
                sio  = (a >= 32'h0301_0000) && (a < 32'h0301_2000);
                fdc  = (a >= 32'h0301_2000) && (a <= 32'h0302_a000);
                if (bank == 3'd0)
                begin
                    r.target = TGT_IOC;
                    r.local_offset = a[26:0];
                end
                else if (bank == 3'd1 || bank == 3'd2)
                begin
                    if (!wr)
                    begin
                        if (a == 32'h0331_0000 && c.old_io_controller)
                        begin
                            r.target = TGT_MOUSE;
                            r.local_offset = a[26:0];
                        end
                        else if (by && fdc)
                        begin
                            r.target = TGT_FDC;
                            r.local_offset = a[26:0];
                        end
                        else if (by && (a & 32'h00ff_f400) == 32'h0002_b000)
                            r.unmapped_data = 32'hffff_ffff;   // network card window
                        else if (sio)
                        begin
                            if (!by && a[11:2] == 10'h1f0)
                                r.target = TGT_IDEW;
                            else
                            begin
                                r.target = TGT_SUPERIO;
                                r.local_offset = a[26:0];
                            end
                        end
                    end
                    else if (!by)
                    begin
                        if (sio)
                        begin
                            if (a[11:2] == 10'h1f0)
                                r.target = TGT_IDEW;
                            else
                            begin
                                r.target = TGT_SUPERIO;
                                r.local_offset = a[26:0];
                            end
                        end
                    end
                    else if (a != 32'h0331_0000 && (a & 32'h00fc_0000) != 32'h0024_0000)
                    begin
                        // byte writes outside the dropped addresses
                        if (fdc)
                        begin
                            r.target = TGT_FDC;
                            r.local_offset = a[26:0];
                        end
                        else if (sio)
                        begin
                            r.target = TGT_SUPERIO;
                            r.local_offset = a[26:0];
                        end
                    end
                end
                else if (bank == 3'd4 || bank == 3'd7)
                begin
                    r.target = TGT_PODULE;
                    r.local_offset = {13'd0, a[13:0]};
                    r.slot = {bank == 3'd7, a[15:14]};
                end
            end
            else if (wr && !by && a[23:22] == 2'b01)
                r.target = TGT_VIDEO;
            else if (c.second_model_mode)
            begin
                if (!by && (a & 32'h00cf_fffc) == 32'h0080_07c0)
                    r.target = TGT_IDEW;
                else if (by && (a & 32'h00cf_f000) == 32'h0080_0000)
                begin
                    r.target = TGT_IDEB;
                    r.local_offset = {17'd0, a[11:2]};
                end
            end
        end
        else if (chunk >= 8'd8 && chunk <= 8'd15)
        begin
            r.target = TGT_PODULE;
            r.local_offset = {3'd0, a[23:0]};
            r.slot = chunk[2:0];
            r.easi_space = 1'b1;
        end
        else if (chunk >= 8'd16 && chunk <= 8'd19)
        begin
            masked = a & {6'd0, c.ram_bank_mask};
            r.target = TGT_BANK0;
            r.local_offset = masked[26:0];
            // frame buffer in main RAM only when no video RAM is fitted
            if (wr && c.vram_mask == '0 && a[31:22] == c.video_start_region)
            begin
                r.dirty_valid = 1'b1;
                r.dirty_page = masked[25:12];
            end
        end
        else if (chunk >= 8'd20 && chunk <= 8'd23)
        begin
            masked = a & {6'd0, c.ram_bank_mask};
            r.target = TGT_BANK1;
            r.local_offset = masked[26:0];
        end
        else if (chunk >= 8'd24 && chunk <= 8'd31)
        begin
            if (c.simm1_present)
            begin
                r.target = TGT_SIMM1;
                r.local_offset = a[26:0];
            end
        end

        if (r.target != TGT_NONE || wr)
            r.unmapped_data = 32'h0;
        if (wr && r.target != TGT_NONE)
        begin
            if (by)
                r.device_data = {24'd0, wd[7:0]};
            else if (r.target == TGT_PODULE && !r.easi_space)
                r.device_data = {16'd0, wd[31:16]};
            else
                r.device_data = wd;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            cfg_now.second_model_mode  = 1'b0;
            cfg_now.old_io_controller  = 1'b1;
            cfg_now.ram_bank_mask      = 26'h01f_ffff;
            cfg_now.vram_mask          = '0;
            cfg_now.simm1_present      = 1'b0;
            cfg_now.video_start_region = '0;
            expected_decodes.delete();
            result_count = 0;
            errors = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_SECOND_MODEL: cfg_now.second_model_mode  = cfg_wdata[0];
                    CFG_OLD_IOC:      cfg_now.old_io_controller  = cfg_wdata[0];
                    CFG_RAM_MASK:     cfg_now.ram_bank_mask      = cfg_wdata[25:0];
                    CFG_VRAM_MASK:    cfg_now.vram_mask          = cfg_wdata[22:0];
                    CFG_SIMM1:        cfg_now.simm1_present      = cfg_wdata[0];
                    CFG_VIDEO_START:  cfg_now.video_start_region = cfg_wdata[9:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_decodes.push_back(decode_access(in_data, cfg_now));
            if (out_valid && out_ready)
            begin
                if (expected_decodes.size() == 0)
                    report_mismatch("result with no transaction outstanding");
                else
                begin
                    want = expected_decodes.pop_front();
                    if (out_data.target !== want.target)
                        report_mismatch($sformatf("target %0d, expected %0d",
                                                  out_data.target, want.target));
                    if (out_data.local_offset !== want.local_offset)
                        report_mismatch($sformatf("local_offset %h, expected %h",
                                                  out_data.local_offset, want.local_offset));
                    if (out_data.slot !== want.slot)
                        report_mismatch($sformatf("slot %0d, expected %0d",
                                                  out_data.slot, want.slot));
                    if (out_data.easi_space !== want.easi_space)
                        report_mismatch($sformatf("easi_space %b, expected %b",
                                                  out_data.easi_space, want.easi_space));
                    if (out_data.device_data !== want.device_data)
                        report_mismatch($sformatf("device_data %h, expected %h",
                                                  out_data.device_data, want.device_data));
                    if (out_data.unmapped_data !== want.unmapped_data)
                        report_mismatch($sformatf("unmapped_data %h, expected %h",
                                                  out_data.unmapped_data, want.unmapped_data));
                    if (out_data.dirty_valid !== want.dirty_valid)
                        report_mismatch($sformatf("dirty_valid %b, expected %b",
                                                  out_data.dirty_valid, want.dirty_valid));
                    if (out_data.dirty_page !== want.dirty_page)
                        report_mismatch($sformatf("dirty_page %h, expected %h",
                                                  out_data.dirty_page, want.dirty_page));
                end
                result_count++;
            end
            pending <= expected_decodes.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the physical address decoder: clock, reset, register setup,
// directed and random bus transactions, receiver stalls and the verdict.
// Depends on pad_pkg, physical_address_decoder and pad_decode_checker.
`timescale 1ns / 1ps

module tb_top;
    import pad_pkg::*;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;
    localparam logic ACC_WORD = 1'b0;
    localparam logic ACC_BYTE = 1'b1;
    localparam int   IDLE_LIMIT = 2000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    req_t                  in_data;
    logic                  out_valid;
    logic                  out_ready;
    rsp_t                  out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    pending;
    int                    errors;
    int                    idle_cycles;
    int                    burst_left;
    logic [9:0]            cur_video_start;

    physical_address_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    pad_decode_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pending   (pending),
        .errors    (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic req_t mk_access(logic op, logic by, logic [31:0] addr,
                                       logic [31:0] data);
        req_t rq;
        rq.op          = op;
        rq.byte_access = by;
        rq.bus_address = addr;
        rq.write_data  = data;
        return rq;
    endfunction

    // Weighted toward the decode regions and their corner addresses.
    function automatic req_t random_access();
        req_t        rq;
        logic [31:0] a;
        logic [31:0] r32;
        int          pick;
        r32  = $urandom;
        pick = $urandom_range(0, 19);
        case (pick)
            0, 1: a = $urandom;
            2:    a = {8'h00, r32[23:0]};
            3:    a = {8'h02, r32[23:0]};
            4:    a = 32'h0300_0000 | (r32 & 32'h0000_ffff);
            5:    a = 32'h0301_0000 | (r32 & 32'h0000_1fff);
            6:    a = 32'h0301_07c0 | (r32 & 32'h0000_0003);
            7:    a = 32'h0301_2000 + (r32 % 32'h0001_8001);
            8:    a = 32'h0302_b000 | (r32 & 32'h0000_0bff);
            9:    a = r32[31] ? 32'h0331_0000 : (32'h033a_0000 | (r32 & 32'h0000_ffff));
            10:   a = {8'h03, 5'd0, r32[31] ? 3'd7 : 3'd4, r32[15:0]};
            11:   a = {8'h03, 2'b01, r32[21:0]};
            12:   a = r32[31] ? (32'h0380_07c0 | (r32 & 32'h0030_0003))
                              : (32'h0380_0000 | (r32 & 32'h0030_0fff));
            13:   a = {8'h03, r32[23:0]};
            14:   a = {5'b00001, r32[26:0]};
            15:   a = r32[31] ? {cur_video_start, r32[21:0]} : {6'b000100, r32[25:0]};
            16:   a = {6'b000101, r32[25:0]};
            17:   a = {5'b00011, r32[26:0]};
            18:   a = {r32[31] ? 8'h01 : {6'b000001, r32[25:24]}, r32[23:0]};
            default: a = {3'b001, r32[28:0]};
        endcase
        // upper bits are masked away in either mode
        if (pick != 19 && $urandom_range(0, 1))
            a[31:30] = 2'($urandom_range(0, 3));
        rq.op          = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
        rq.byte_access = $urandom_range(0, 1) ? ACC_BYTE : ACC_WORD;
        rq.bus_address = a;
        case ($urandom_range(0, 7))
            0:       rq.write_data = 32'h0;
            1:       rq.write_data = 32'hffff_ffff;
            default: rq.write_data = $urandom;
        endcase
        return rq;
    endfunction

    // Offers one transaction; the sender runs in bursts with gaps between them.
    task automatic offer(input req_t rq);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= rq;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic sm, input logic oi, input logic [25:0] rm,
                                 input logic [22:0] vm, input logic s1, input logic [9:0] vs);
        write_reg(CFG_SECOND_MODEL, {25'd0, sm});
        write_reg(CFG_OLD_IOC, {25'd0, oi});
        write_reg(CFG_RAM_MASK, rm);
        write_reg(CFG_VRAM_MASK, {3'd0, vm});
        write_reg(CFG_SIMM1, {25'd0, s1});
        write_reg(CFG_VIDEO_START, {16'd0, vs});
        cfg_we <= 1'b0;
        cur_video_start = vs;
    endtask

    task automatic random_setting();
        logic [25:0] rm;
        logic [22:0] vm;
        logic [9:0]  vs;
        if ($urandom_range(0, 2) == 0)
            rm = 26'($urandom_range(32'h001f_ffff, 32'h03ff_ffff));
        else
            rm = 26'((32'd1 << $urandom_range(21, 26)) - 1);
        case ($urandom_range(0, 2))
            0:       vm = '0;
            1:       vm = 23'((32'd1 << $urandom_range(1, 23)) - 1);
            default: vm = 23'($urandom_range(1, 32'h007f_ffff));
        endcase
        // mostly place the frame buffer inside the first SIMM0 bank
        vs = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                         : 10'($urandom_range(64, 79));
        apply_setting(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rm, vm,
                      1'($urandom_range(0, 1)), vs);
    endtask

    task automatic run_random(input int count);
        repeat (count) offer(random_access());
    endtask

    // Receiver: a long hold-off on the first offered transaction, then mixed stretches.
    initial
    begin
        int mode;
        int len;
        out_ready = 1'b0;
        @(posedge clk);
        while (!(rst_n && in_valid)) @(posedge clk);
        repeat (64) @(posedge clk);
        forever
        begin
            mode = $urandom_range(0, 11);
            len  = $urandom_range(10, 60);
            if (mode == 0)
            begin
                out_ready <= 1'b0;
                repeat (48) @(posedge clk);
            end
            else if (mode <= 4)
            begin
                out_ready <= 1'b1;
                repeat (len) @(posedge clk);
            end
            else
            begin
                repeat (len)
                begin
                    out_ready <= ($urandom_range(0, 3) != 0);
                    @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        in_valid        = 1'b0;
        in_data         = '0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        rst_n           = 1'b0;
        burst_left      = 0;
        cur_video_start = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 512MB, old I/O controller, no video RAM, no SIMM1
        offer(mk_access(OP_READ,  ACC_WORD, 32'h0000_0000, 32'h0));
        offer(mk_access(OP_READ,  ACC_BYTE, 32'hffff_ffff, 32'hffff_ffff));
        offer(mk_access(OP_WRITE, ACC_WORD, 32'h0012_3456, 32'hffff_ffff));
        offer(mk_access(OP_READ,  ACC_WORD, 32'h0200_0000, 32'h0));
        offer(mk_access(OP_READ,  ACC_BYTE, 32'h0200_0010, 32'h0));
        offer(mk_access(OP_READ,  ACC_WORD, 32'h0300_0004, 32'h0));
        offer(mk_access(OP_READ,  ACC_BYTE, 32'h0331_0000, 32'h0));
        offer(mk_access(OP_READ,  ACC_BYTE, 32'h0301_2000, 32'h0));
        offer(mk_access(OP_WRITE, ACC_BYTE, 32'h0302_a000, 32'h1234_565a));
        offer(mk_access(OP_READ,  ACC_BYTE, 32'h0302_b004, 32'h0));
        offer(mk_access(OP_READ,  ACC_WORD, 32'h0301_07c0, 32'h0));
        offer(mk_access(OP_WRITE, ACC_WORD, 32'h0301_0100, 32'h8765_4321));
        offer(mk_access(OP_WRITE, ACC_BYTE, 32'h0331_0000, 32'h0000_00ff));
        offer(mk_access(OP_WRITE, ACC_BYTE, 32'h033a_0004, 32'h0000_0011));
        offer(mk_access(OP_WRITE, ACC_WORD, 32'h0307_c004, 32'hdead_beef));
        offer(mk_access(OP_WRITE, ACC_WORD, 32'h0340_0000, 32'h0bad_cafe));
        offer(mk_access(OP_WRITE, ACC_WORD, 32'h0f12_3456, 32'hdead_beef));
        offer(mk_access(OP_WRITE, ACC_WORD, 32'h1000_0000, 32'h5555_aaaa));
        offer(mk_access(OP_READ,  ACC_WORD, 32'h1400_0000, 32'h0));
        offer(mk_access(OP_READ,  ACC_WORD, 32'h1800_0000, 32'h0));
        offer(mk_access(OP_READ,  ACC_WORD, 32'h0380_07c0, 32'h0));
        drain();

        // upper extremes: 1GB space, second IDE decode, all memory fitted
        apply_setting(1'b1, 1'b0, 26'h3ff_ffff, 23'h7f_ffff, 1'b1, 10'd1023);
        offer(mk_access(OP_READ,  ACC_WORD, 32'h0380_07c0, 32'h0));
        offer(mk_access(OP_READ,  ACC_BYTE, 32'h0380_03fc, 32'h0));
        offer(mk_access(OP_WRITE, ACC_BYTE, 32'h02ff_fffc, 32'h0));
        offer(mk_access(OP_READ,  ACC_WORD, 32'h3fff_ffff, 32'h0));
        offer(mk_access(OP_READ,  ACC_WORD, 32'h0331_0000, 32'h0));
        offer(mk_access(OP_WRITE, ACC_WORD, 32'h1fff_ffff, 32'hffff_ffff));
        drain();

        // lower extremes, frame buffer in main RAM
        apply_setting(1'b0, 1'b1, 26'h01f_ffff, 23'h0, 1'b0, 10'd64);
        run_random(200);
        drain();

        apply_setting(1'b1, 1'b0, 26'h3ff_ffff, 23'h7f_ffff, 1'b1, 10'd1023);
        run_random(200);
        drain();

        repeat (6)
        begin
            random_setting();
            run_random(200);
            drain();
        end

        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
